/* sv/mi3_pkg.sv */
package mi3_pkg;

	localparam int ELEM_W    = 32;
	localparam int FRAC_BITS = 16;
	localparam int N_EL      = 9;
	// quotient bits produced by the divider lanes
	localparam int QBITS     = 2 * FRAC_BITS;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int COF_W     = PROD_W + 1;
	localparam int LO_W      = ELEM_W;
	localparam int HI_W      = COF_W - LO_W;
	localparam int PART_W    = ELEM_W + HI_W;
	localparam int TERM_W    = ELEM_W + COF_W;
	localparam int DET_W     = TERM_W + 2;
	localparam int REM_W     = DET_W + 1;
	localparam int CMP_W     = (QBITS > ELEM_W) ? QBITS : ELEM_W;
	localparam int FRONT_ST  = 7;
	localparam int LANE_ST   = QBITS + 1;
	localparam int NST       = FRONT_ST + LANE_ST;

	typedef logic signed [ELEM_W-1:0] elem_t;

	typedef struct packed {
		logic             zero;
		logic             neg;
		logic [DET_W-1:0] mag;
	} det_info_t;

	typedef struct packed {
		logic [QBITS-1:0] q;
		logic             ovf;
		logic             neg;
		logic             zero;
		elem_t            raw;
	} lane_out_t;

endpackage

/* sv/mi3_front.sv */
module mi3_front (
	input  logic                                    clk,
	input  logic [mi3_pkg::FRONT_ST-1:0]            adv,
	input  mi3_pkg::elem_t [mi3_pkg::N_EL-1:0]      m,
	output mi3_pkg::elem_t [mi3_pkg::N_EL-1:0]      raw,
	output logic [mi3_pkg::N_EL-1:0][mi3_pkg::COF_W-1:0] adj_mag,
	output logic [mi3_pkg::N_EL-1:0]                adj_neg,
	output mi3_pkg::det_info_t                      det_info
);
	import mi3_pkg::*;

	// operand pairs of each cofactor, in adjugate order: adj = m[PA]*m[PB] - m[PA']*m[PB']
	localparam int PA [2*N_EL] = '{4, 5, 2, 1, 1, 2, 5, 3, 0, 2, 2, 0, 3, 4, 1, 0, 0, 1};
	localparam int PB [2*N_EL] = '{8, 7, 7, 8, 5, 4, 6, 8, 8, 6, 3, 5, 7, 6, 6, 7, 4, 3};

	elem_t [N_EL-1:0]                m_s1, m_s2, m_s3, m_s4, m_s5, m_s6, m_s7;
	logic [2*N_EL-1:0][PROD_W-1:0]   p_s2;
	logic [N_EL-1:0][COF_W-1:0]      cof_s3, cof_s4, cof_s5, cof_s6;
	logic [2:0][PART_W-1:0]          pl_s4, ph_s4;
	logic [2:0][TERM_W-1:0]          t_s5;
	logic [DET_W-1:0]                det_s6;
	logic [N_EL-1:0][COF_W-1:0]      am_s7;
	logic [N_EL-1:0]                 an_s7;
	det_info_t                       di_s7;

	always_ff @(posedge clk) begin
		if (adv[0]) m_s1 <= m;
		if (adv[1]) m_s2 <= m_s1;
		if (adv[2]) m_s3 <= m_s2;
		if (adv[3]) begin
			m_s4   <= m_s3;
			cof_s4 <= cof_s3;
		end
		if (adv[4]) begin
			m_s5   <= m_s4;
			cof_s5 <= cof_s4;
		end
		if (adv[5]) begin
			m_s6   <= m_s5;
			cof_s6 <= cof_s5;
			det_s6 <= $signed({{2{t_s5[0][TERM_W-1]}}, t_s5[0]})
				+ $signed({{2{t_s5[1][TERM_W-1]}}, t_s5[1]})
				+ $signed({{2{t_s5[2][TERM_W-1]}}, t_s5[2]});
		end
		if (adv[6]) begin
			m_s7       <= m_s6;
			di_s7.zero <= (det_s6 == '0);
			di_s7.neg  <= det_s6[DET_W-1];
			di_s7.mag  <= det_s6[DET_W-1] ? -det_s6 : det_s6;
		end
	end

	genvar gk;
	generate
		for (gk = 0; gk < 2*N_EL; gk++) begin : g_prod
			always_ff @(posedge clk) begin
				if (adv[1]) p_s2[gk] <= PROD_W'($signed(m_s1[PA[gk]]) * $signed(m_s1[PB[gk]]));
			end
		end
		for (gk = 0; gk < N_EL; gk++) begin : g_cof
			always_ff @(posedge clk) begin
				if (adv[2]) begin
					cof_s3[gk] <= $signed({p_s2[2*gk][PROD_W-1], p_s2[2*gk]})
						- $signed({p_s2[2*gk+1][PROD_W-1], p_s2[2*gk+1]});
				end
				if (adv[6]) begin
					an_s7[gk] <= cof_s6[gk][COF_W-1];
					am_s7[gk] <= cof_s6[gk][COF_W-1] ? -cof_s6[gk] : cof_s6[gk];
				end
			end
		end
		// row-0 expansion: split each cofactor into a low unsigned and high signed half
		for (gk = 0; gk < 3; gk++) begin : g_det
			always_ff @(posedge clk) begin
				if (adv[3]) begin
					pl_s4[gk] <= PART_W'($signed(m_s3[gk])
						* $signed({1'b0, cof_s3[3*gk][LO_W-1:0]}));
					ph_s4[gk] <= PART_W'($signed(m_s3[gk])
						* $signed(cof_s3[3*gk][COF_W-1:LO_W]));
				end
				if (adv[4]) begin
					t_s5[gk] <= $signed({ph_s4[gk], {LO_W{1'b0}}})
						+ $signed({{(TERM_W-PART_W){pl_s4[gk][PART_W-1]}}, pl_s4[gk]});
				end
			end
		end
	endgenerate

	assign raw      = m_s7;
	assign adj_mag  = am_s7;
	assign adj_neg  = an_s7;
	assign det_info = di_s7;

endmodule

/* sv/mi3_div_lane.sv */
module mi3_div_lane (
	input  logic                          clk,
	input  logic [mi3_pkg::LANE_ST-1:0]   adv,
	input  logic [mi3_pkg::COF_W-1:0]     adj_mag,
	input  logic                          adj_neg,
	input  mi3_pkg::det_info_t            det_info,
	input  mi3_pkg::elem_t                raw,
	output mi3_pkg::lane_out_t            res
);
	import mi3_pkg::*;

	logic [LANE_ST-1:0][REM_W-1:0] rem_s;
	logic [LANE_ST-1:0][DET_W-1:0] d_s;
	logic [LANE_ST-1:0][QBITS-1:0] q_s;
	logic [LANE_ST-1:0]            ovf_s, neg_s, zero_s;
	elem_t [LANE_ST-1:0]           raw_s;

	// quotient of 2^QBITS or more saturates; it happens exactly when |adj| >= |det|
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			rem_s[0]  <= REM_W'(adj_mag);
			d_s[0]    <= det_info.mag;
			q_s[0]    <= '0;
			ovf_s[0]  <= (DET_W'(adj_mag) >= det_info.mag);
			neg_s[0]  <= adj_neg ^ det_info.neg;
			zero_s[0] <= det_info.zero;
			raw_s[0]  <= raw;
		end
	end

	genvar gk;
	generate
		for (gk = 1; gk < LANE_ST; gk++) begin : g_step
			logic [REM_W-1:0] sh;
			logic             ge;
			always_comb begin
				sh = {rem_s[gk-1][REM_W-2:0], 1'b0};
				ge = (sh >= REM_W'(d_s[gk-1]));
			end
			always_ff @(posedge clk) begin
				if (adv[gk]) begin
					rem_s[gk]  <= ge ? sh - REM_W'(d_s[gk-1]) : sh;
					q_s[gk]    <= {q_s[gk-1][QBITS-2:0], ge};
					d_s[gk]    <= d_s[gk-1];
					ovf_s[gk]  <= ovf_s[gk-1];
					neg_s[gk]  <= neg_s[gk-1];
					zero_s[gk] <= zero_s[gk-1];
					raw_s[gk]  <= raw_s[gk-1];
				end
			end
		end
	endgenerate

	assign res.q    = q_s[LANE_ST-1];
	assign res.ovf  = ovf_s[LANE_ST-1];
	assign res.neg  = neg_s[LANE_ST-1];
	assign res.zero = zero_s[LANE_ST-1];
	assign res.raw  = raw_s[LANE_ST-1];

endmodule

/* sv/mi3_merge.sv */
module mi3_merge (
	input  logic                                  clk,
	input  logic                                  adv,
	input  mi3_pkg::lane_out_t [mi3_pkg::N_EL-1:0] lanes,
	output mi3_pkg::elem_t [mi3_pkg::N_EL-1:0]    r,
	output logic                                  singular
);
	import mi3_pkg::*;

	localparam logic [ELEM_W-1:0] LIM = {1'b1, {(ELEM_W-1){1'b0}}};

	elem_t [N_EL-1:0] r_q;
	logic             sing_q;
	elem_t [N_EL-1:0] val;

	always_comb begin
		logic [ELEM_W-1:0] mag;
		for (int i = 0; i < N_EL; i++) begin
			if (lanes[i].neg) begin
				mag = (lanes[i].ovf || CMP_W'(lanes[i].q) > CMP_W'(LIM))
					? LIM : ELEM_W'(lanes[i].q);
				val[i] = -mag;
			end else begin
				mag = (lanes[i].ovf || CMP_W'(lanes[i].q) > CMP_W'(LIM - 1'b1))
					? LIM - 1'b1 : ELEM_W'(lanes[i].q);
				val[i] = mag;
			end
		end
	end

	// singular: echo the input beat
	always_ff @(posedge clk) begin
		if (adv) begin
			sing_q <= lanes[0].zero;
			for (int i = 0; i < N_EL; i++) begin
				r_q[i] <= lanes[0].zero ? lanes[i].raw : val[i];
			end
		end
	end

	assign r        = r_q;
	assign singular = sing_q;

endmodule

/* sv/matrix3_inverse_adjugate_core.sv */
// channel  | handshake            | payload
// input    | in_valid / in_stall  | m00 .. m22
// output   | out_valid / out_stall| r00 .. r22, singular
//
// One matrix beat per cycle while out_stall is low.
// Most pipeline stages are the 32 one-bit restoring steps of the nine divider lanes.
// Each stage loads whenever it is empty or the stage after it moves, so bubbles close.
// arst_n clears only the valid bits; payload registers are not reset.
module matrix3_inverse_adjugate_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mi3_pkg::elem_t      m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic                out_valid,
	input  logic                out_stall,
	output mi3_pkg::elem_t      r00, r01, r02, r10, r11, r12, r20, r21, r22,
	output logic                singular
);
	import mi3_pkg::*;

	logic [NST-1:0]             v_q;
	logic                       ov_q;
	logic [NST:0]               adv;
	elem_t [N_EL-1:0]           m_in, raw, r;
	logic [N_EL-1:0][COF_W-1:0] adj_mag;
	logic [N_EL-1:0]            adj_neg;
	det_info_t                  det_info;
	lane_out_t [N_EL-1:0]       lanes;

	always_comb begin
		adv[NST] = !ov_q || !out_stall;
		for (int k = NST - 1; k >= 0; k--) begin
			adv[k] = !v_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q  <= '0;
			ov_q <= 1'b0;
		end else begin
			if (adv[0]) v_q[0] <= in_valid;
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) v_q[k] <= v_q[k-1];
			end
			if (adv[NST]) ov_q <= v_q[NST-1];
		end
	end

	assign in_stall  = !adv[0];
	assign out_valid = ov_q;

	assign m_in = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

	mi3_front u_front (
		.clk      (clk),
		.adv      (adv[FRONT_ST-1:0]),
		.m        (m_in),
		.raw      (raw),
		.adj_mag  (adj_mag),
		.adj_neg  (adj_neg),
		.det_info (det_info)
	);

	genvar gi;
	generate
		for (gi = 0; gi < N_EL; gi++) begin : g_lane
			mi3_div_lane u_lane (
				.clk      (clk),
				.adv      (adv[NST-1:FRONT_ST]),
				.adj_mag  (adj_mag[gi]),
				.adj_neg  (adj_neg[gi]),
				.det_info (det_info),
				.raw      (raw[gi]),
				.res      (lanes[gi])
			);
		end
	endgenerate

	mi3_merge u_merge (
		.clk      (clk),
		.adv      (adv[NST]),
		.lanes    (lanes),
		.r        (r),
		.singular (singular)
	);

	assign r00 = r[0];
	assign r01 = r[1];
	assign r02 = r[2];
	assign r10 = r[3];
	assign r11 = r[4];
	assign r12 = r[5];
	assign r20 = r[6];
	assign r21 = r[7];
	assign r22 = r[8];

endmodule
